[design/md2_pkg.sv]
// Shared types and constants of the MD2 hash engine: the pi-derived S-box,
// the sizes of the hash state, the controller states and the mixer control.
// No dependencies; used by md2_mix and md2_hash_engine_core.
package md2_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int STATE_BYTES = 48;
    localparam int ROUNDS      = 18;

    // Substitution table built from the digits of pi.
    localparam logic [7:0] SBOX [256] = '{
        8'h29,8'h2E,8'h43,8'hC9,8'hA2,8'hD8,8'h7C,8'h01,8'h3D,8'h36,8'h54,8'hA1,8'hEC,8'hF0,8'h06,8'h13,
        8'h62,8'hA7,8'h05,8'hF3,8'hC0,8'hC7,8'h73,8'h8C,8'h98,8'h93,8'h2B,8'hD9,8'hBC,8'h4C,8'h82,8'hCA,
        8'h1E,8'h9B,8'h57,8'h3C,8'hFD,8'hD4,8'hE0,8'h16,8'h67,8'h42,8'h6F,8'h18,8'h8A,8'h17,8'hE5,8'h12,
        8'hBE,8'h4E,8'hC4,8'hD6,8'hDA,8'h9E,8'hDE,8'h49,8'hA0,8'hFB,8'hF5,8'h8E,8'hBB,8'h2F,8'hEE,8'h7A,
        8'hA9,8'h68,8'h79,8'h91,8'h15,8'hB2,8'h07,8'h3F,8'h94,8'hC2,8'h10,8'h89,8'h0B,8'h22,8'h5F,8'h21,
        8'h80,8'h7F,8'h5D,8'h9A,8'h5A,8'h90,8'h32,8'h27,8'h35,8'h3E,8'hCC,8'hE7,8'hBF,8'hF7,8'h97,8'h03,
        8'hFF,8'h19,8'h30,8'hB3,8'h48,8'hA5,8'hB5,8'hD1,8'hD7,8'h5E,8'h92,8'h2A,8'hAC,8'h56,8'hAA,8'hC6,
        8'h4F,8'hB8,8'h38,8'hD2,8'h96,8'hA4,8'h7D,8'hB6,8'h76,8'hFC,8'h6B,8'hE2,8'h9C,8'h74,8'h04,8'hF1,
        8'h45,8'h9D,8'h70,8'h59,8'h64,8'h71,8'h87,8'h20,8'h86,8'h5B,8'hCF,8'h65,8'hE6,8'h2D,8'hA8,8'h02,
        8'h1B,8'h60,8'h25,8'hAD,8'hAE,8'hB0,8'hB9,8'hF6,8'h1C,8'h46,8'h61,8'h69,8'h34,8'h40,8'h7E,8'h0F,
        8'h55,8'h47,8'hA3,8'h23,8'hDD,8'h51,8'hAF,8'h3A,8'hC3,8'h5C,8'hF9,8'hCE,8'hBA,8'hC5,8'hEA,8'h26,
        8'h2C,8'h53,8'h0D,8'h6E,8'h85,8'h28,8'h84,8'h09,8'hD3,8'hDF,8'hCD,8'hF4,8'h41,8'h81,8'h4D,8'h52,
        8'h6A,8'hDC,8'h37,8'hC8,8'h6C,8'hC1,8'hAB,8'hFA,8'h24,8'hE1,8'h7B,8'h08,8'h0C,8'hBD,8'hB1,8'h4A,
        8'h78,8'h88,8'h95,8'h8B,8'hE3,8'h63,8'hE8,8'h6D,8'hE9,8'hCB,8'hD5,8'hFE,8'h3B,8'h00,8'h1D,8'h39,
        8'hF2,8'hEF,8'hB7,8'h0E,8'h66,8'h58,8'hD0,8'hE4,8'hA6,8'h77,8'h72,8'hF8,8'hEB,8'h75,8'h4B,8'h0A,
        8'h31,8'h44,8'h50,8'hB4,8'h8F,8'hED,8'h1F,8'h1A,8'hDB,8'h99,8'h8D,8'h33,8'h9F,8'h11,8'h83,8'h14
    };

    // Input kinds carried on tuser.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_MIX,
        ST_FOLD,
        ST_SNAP,
        ST_OUT
    } t_state;

    // Commands from the controller to the mixer.
    typedef struct packed {
        logic load;   // set up the state from the block and start the rounds
        logic shift;  // rotate the state by one byte without change
        logic clear;  // zero the state
    } t_mix_ctl;

    // Status from the mixer to the controller.
    typedef struct packed {
        logic busy;   // rounds in progress
        logic done;   // final step of the final round this cycle
    } t_mix_st;

endpackage

[design/md2_hash_engine_core.sv]
// MD2 hash engine top level: input handshake, block buffer, checksum ring,
// controller and digest output. Depends on md2_pkg and md2_mix.
//
// Message bytes (tuser = 0) are taken one per cycle, while the engine is
// idle, into a 16-byte buffer. The byte that fills a block starts a
// compression: a setup state, then the mixer applies one S-box step per
// cycle (18 rounds over the 48-byte state), then the checksum update, one
// byte per cycle; input is held off until that update is done. A finish
// transfer (tuser = 1, tdata ignored) writes the 16 minus fill padding
// bytes one per cycle, compresses and folds the padded block, copies the
// checksum, compresses it again and then presents the 16 digest bytes,
// state byte 0 first, with tlast on the sixteenth. After the last digest
// byte the mixer state, checksum and fill count are cleared and the next
// message can begin.
module md2_hash_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] digest_byte
    output logic       m_axis_tlast
);
    import md2_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [BLOCK_BYTES-1:0][7:0] r_buf;
    logic [BLOCK_BYTES-1:0][7:0] r_cs;
    logic [3:0]                  r_fill;
    logic [4:0]                  r_pad;
    logic [3:0]                  r_cnt;
    logic [7:0]                  r_l;
    logic                        r_final;
    logic                        r_second;

    t_mix_ctl   mix_ctl;
    t_mix_st    mix_st;
    logic [7:0] mix_head;

    logic       in_xfer;
    logic       out_xfer;
    logic [7:0] fold_l;
    logic [7:0] cs_new;

    md2_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mix_ctl),
        .i_blk   (r_buf),
        .o_st    (mix_st),
        .o_head  (mix_head)
    );

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Checksum step: the first step chains from the last checksum byte.
    always_comb begin
        fold_l = (r_cnt == 4'd0) ? r_cs[BLOCK_BYTES-1] : r_l;
        cs_new = r_cs[0] ^ SBOX[r_buf[0] ^ fold_l];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == OP_FINISH) begin
                        n_state = ST_PAD;
                    end else if (r_fill == 4'(BLOCK_BYTES - 1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == 4'(BLOCK_BYTES - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_MIX;
            ST_MIX: begin
                if (mix_st.done) begin
                    n_state = r_second ? ST_OUT : ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_cnt == 4'(BLOCK_BYTES - 1)) begin
                    n_state = r_final ? ST_SNAP : ST_IDLE;
                end
            end
            ST_SNAP: n_state = ST_LOAD;
            ST_OUT: begin
                if (out_xfer && r_cnt == 4'(BLOCK_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mix_ctl       = '0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_LOAD: mix_ctl.load = 1'b1;
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                mix_ctl.shift = m_axis_tready;
                mix_ctl.clear = m_axis_tready && (r_cnt == 4'(BLOCK_BYTES - 1));
            end
            default: ;
        endcase
    end

    assign m_axis_tdata = mix_head;
    assign m_axis_tlast = (r_cnt == 4'(BLOCK_BYTES - 1));

    // State register and control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_pad    <= '0;
            r_cnt    <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_cs     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (s_axis_tuser == OP_FINISH) begin
                            r_pad   <= 5'(BLOCK_BYTES) - {1'b0, r_fill};
                            r_final <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 4'd1;
                        end
                    end
                end
                ST_PAD: r_fill <= r_fill + 4'd1;
                ST_FOLD: begin
                    r_cs  <= {cs_new, r_cs[BLOCK_BYTES-1:1]};
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_SNAP: r_second <= 1'b1;
                ST_OUT: begin
                    if (out_xfer) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'(BLOCK_BYTES - 1)) begin
                            r_cs     <= '0;
                            r_fill   <= '0;
                            r_final  <= 1'b0;
                            r_second <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Block buffer shift line and checksum chaining byte.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && s_axis_tuser == OP_ABSORB) begin
                    r_buf <= {s_axis_tdata, r_buf[BLOCK_BYTES-1:1]};
                end
            end
            ST_PAD:  r_buf <= {{3'b000, r_pad}, r_buf[BLOCK_BYTES-1:1]};
            ST_FOLD: begin
                r_buf <= {r_buf[0], r_buf[BLOCK_BYTES-1:1]};
                r_l   <= cs_new;
            end
            ST_SNAP: r_buf <= r_cs;
            default: ;
        endcase
    end

    // Input is never taken while the mixer is running.
    a_no_input_while_mixing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !mix_st.busy)
        else $error("input ready while mixer busy");

    // The mixer only finishes while the controller waits for it.
    a_done_in_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_st.done |-> r_state == ST_MIX)
        else $error("mixer done outside of the mix state");

    // After the last digest byte the message state is cleared.
    a_clear_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tlast |=> r_fill == 4'd0 && r_cs == '0 && !r_final)
        else $error("state not cleared after digest");

endmodule

[design/md2_mix.sv]
// MD2 compression unit: the 48-byte state held as a byte-wide ring that
// applies one S-box step per cycle, 18 rounds of 48 steps per block.
// Depends on md2_pkg.
module md2_mix (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  md2_pkg::t_mix_ctl                i_ctl,
    input  logic [md2_pkg::BLOCK_BYTES-1:0][7:0] i_blk,
    output md2_pkg::t_mix_st                 o_st,
    output logic [7:0]                       o_head
);
    import md2_pkg::*;

    logic [STATE_BYTES-1:0][7:0] r_x;
    logic [7:0]                  r_t;
    logic [5:0]                  r_step;
    logic [4:0]                  r_round;
    logic                        r_busy;

    logic [7:0] x_new;
    logic       last_step;
    logic       last_round;

    // One S-box step on the byte at the head of the ring.
    always_comb begin
        x_new      = r_x[0] ^ SBOX[r_t];
        last_step  = (r_step == 6'(STATE_BYTES - 1));
        last_round = (r_round == 5'(ROUNDS - 1));
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_busy && last_step && last_round;
    assign o_head    = r_x[0];

    // State ring, round and step counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_t     <= '0;
            r_step  <= '0;
            r_round <= '0;
            r_busy  <= 1'b0;
        end else if (i_ctl.clear) begin
            r_x    <= '0;
            r_busy <= 1'b0;
        end else if (i_ctl.load) begin
            // Upper thirds take the block and the block XOR the lower third.
            r_x[3*BLOCK_BYTES-1:2*BLOCK_BYTES] <= r_x[BLOCK_BYTES-1:0] ^ i_blk;
            r_x[2*BLOCK_BYTES-1:BLOCK_BYTES]   <= i_blk;
            r_t     <= '0;
            r_step  <= '0;
            r_round <= '0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_x <= {x_new, r_x[STATE_BYTES-1:1]};
            if (last_step) begin
                r_step  <= '0;
                r_t     <= x_new + {3'b000, r_round};
                r_round <= r_round + 5'd1;
                if (last_round) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_step <= r_step + 6'd1;
                r_t    <= x_new;
            end
        end else if (i_ctl.shift) begin
            r_x <= {r_x[0], r_x[STATE_BYTES-1:1]};
        end
    end

    // A new run of rounds only starts from a load command.
    a_start_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(i_ctl.load))
        else $error("mixer started without a load");

    // The step counter never passes the end of the ring.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 6'(STATE_BYTES - 1))
        else $error("mixer step counter out of range");

    // While rounds run, the round counter stays below the round count.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_round <= 5'(ROUNDS - 1))
        else $error("mixer round counter out of range");

endmodule
